[rtl/ppamc_pkg.sv]
package ppamc_pkg;

  localparam int SLOT_COUNT  = 32;
  localparam int LIFETIME    = 64;
  localparam int MAX_RESULTS = 32;

  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int EMIT_COUNT = (SLOT_COUNT < MAX_RESULTS) ? SLOT_COUNT : MAX_RESULTS;
  localparam int PHASE_DIV  = (LIFETIME / 4 == 0) ? 1 : LIFETIME / 4;

  localparam int AGE_W   = 9;
  localparam int POS_W   = 20;
  localparam int VEL_W   = 16;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 32;
  localparam int INDEX_W = 6;
  localparam int CFG_W   = 2;

  localparam logic [1:0] REQ_SPAWN = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] CFG_COLOR_YOUNG = 2'd0;
  localparam logic [CFG_W-1:0] CFG_COLOR_MID   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_COLOR_OLD   = 2'd2;
  localparam logic [CFG_W-1:0] CFG_COLOR_DYING = 2'd3;

  localparam logic [COLOR_W-1:0] COLOR_YOUNG_RST = 32'hEBFF00FF;
  localparam logic [COLOR_W-1:0] COLOR_MID_RST   = 32'hEBC600FF;
  localparam logic [COLOR_W-1:0] COLOR_OLD_RST   = 32'hD36B00FF;
  localparam logic [COLOR_W-1:0] COLOR_DYING_RST = 32'hBE1A00FF;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] spawn_x;
    logic signed [POS_W-1:0] spawn_y;
    logic signed [VEL_W-1:0] spawn_dx;
    logic signed [VEL_W-1:0] spawn_dy;
  } req_t;

  typedef struct packed {
    logic [1:0]              result_kind;
    logic [INDEX_W-1:0]      slot_index;
    logic                    flag;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic              spawn;
    logic              clear;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic [AGE_W-1:0]        age;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } slot_rec_t;

endpackage

[rtl/ppamc_ctrl.sv]
module ppamc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          req_type,
  output logic                busy,
  output ppamc_pkg::cmd_t     cmd
);
  import ppamc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] cnt_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd.spawn   = 1'b0;
    cmd.clear   = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = cnt;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_SPAWN: cmd.spawn = 1'b1;
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_FRAME: begin
              state_next = ST_WALK;
              cnt_next   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.rd_en = 1'b1;
        if (cnt == LAST_SLOT) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[rtl/ppamc_datapath.sv]
module ppamc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ppamc_pkg::cmd_t              cmd,
  input  ppamc_pkg::req_t              req,
  input  logic                         cfg_we,
  input  logic [ppamc_pkg::CFG_W-1:0]  cfg_addr,
  input  logic [ppamc_pkg::COLOR_W-1:0] cfg_data,
  output ppamc_pkg::result_t           result,
  output logic                         valid
);
  import ppamc_pkg::*;

  localparam logic [AGE_W-1:0] AGE_LIMIT = AGE_W'(LIFETIME);
  localparam logic [AGE_W-1:0] PHASE1    = AGE_W'(PHASE_DIV);
  localparam logic [AGE_W-1:0] PHASE2    = AGE_W'(2 * PHASE_DIV);
  localparam logic [AGE_W-1:0] PHASE3    = AGE_W'(3 * PHASE_DIV);

  slot_rec_t mem [SLOT_COUNT];
  slot_rec_t rd_data;

  logic [SLOT_COUNT-1:0] live;
  logic [COLOR_W-1:0]    color_young;
  logic [COLOR_W-1:0]    color_mid;
  logic [COLOR_W-1:0]    color_old;
  logic [COLOR_W-1:0]    color_dying;

  logic              s1_valid;
  logic [SLOT_W-1:0] s1_idx;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic                    live_cur;
  logic [AGE_W-1:0]        age_inc;
  logic                    expire;
  logic [POS_W:0]          sum_x;
  logic [POS_W:0]          sum_y;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic [COLOR_W-1:0]      phase_color;
  logic                    emit;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_rec_t         mem_wdata;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    live_cur = live[s1_idx];
    age_inc  = rd_data.age + 1'b1;
    expire   = (age_inc > AGE_LIMIT);
    sum_x = {rd_data.pos_x[POS_W-1], rd_data.pos_x}
          + {{(POS_W-VEL_W+1){rd_data.vel_x[VEL_W-1]}}, rd_data.vel_x};
    sum_y = {rd_data.pos_y[POS_W-1], rd_data.pos_y}
          + {{(POS_W-VEL_W+1){rd_data.vel_y[VEL_W-1]}}, rd_data.vel_y};
    if (sum_x[POS_W] != sum_x[POS_W-1]) begin
      new_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      new_x = sum_x[POS_W-1:0];
    end
    if (sum_y[POS_W] != sum_y[POS_W-1]) begin
      new_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      new_y = sum_y[POS_W-1:0];
    end
    if (age_inc >= PHASE3) begin
      phase_color = color_dying;
    end else if (age_inc >= PHASE2) begin
      phase_color = color_old;
    end else if (age_inc >= PHASE1) begin
      phase_color = color_mid;
    end else begin
      phase_color = color_young;
    end
    emit = (int'(s1_idx) < EMIT_COUNT);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{age: '0, pos_x: req.spawn_x, pos_y: req.spawn_y,
                  vel_x: req.spawn_dx, vel_y: req.spawn_dy};
    if (cmd.spawn) begin
      mem_we = free_found;
    end else if (s1_valid && live_cur && !expire) begin
      mem_we    = 1'b1;
      mem_waddr = s1_idx;
      mem_wdata = '{age: age_inc, pos_x: new_x, pos_y: new_y,
                    vel_x: rd_data.vel_x, vel_y: rd_data.vel_y};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live        <= '0;
      s1_valid    <= 1'b0;
      valid       <= 1'b0;
      color_young <= COLOR_YOUNG_RST;
      color_mid   <= COLOR_MID_RST;
      color_old   <= COLOR_OLD_RST;
      color_dying <= COLOR_DYING_RST;
    end else begin
      s1_valid <= cmd.rd_en;
      valid    <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COLOR_YOUNG: color_young <= cfg_data;
          CFG_COLOR_MID:   color_mid   <= cfg_data;
          CFG_COLOR_OLD:   color_old   <= cfg_data;
          CFG_COLOR_DYING: color_dying <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.spawn) begin
        valid <= 1'b1;
        if (free_found) begin
          live[free_idx] <= 1'b1;
        end
      end
      if (cmd.clear) begin
        valid <= 1'b1;
        live  <= '0;
      end
      if (s1_valid) begin
        valid <= emit;
        if (live_cur && expire) begin
          live[s1_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= cmd.rd_addr;
    if (cmd.spawn) begin
      result <= '{result_kind: KIND_SPAWN,
                  slot_index: free_found ? INDEX_W'(free_idx) : '0,
                  flag: free_found, pixel_x: '0, pixel_y: '0,
                  pixel_color: '0, last: 1'b1};
    end else if (cmd.clear) begin
      result <= '{result_kind: KIND_CLEAR, slot_index: '0, flag: 1'b0,
                  pixel_x: '0, pixel_y: '0, pixel_color: '0, last: 1'b1};
    end else if (s1_valid) begin
      result.result_kind <= KIND_PIXEL;
      result.slot_index  <= INDEX_W'(s1_idx);
      result.last        <= (int'(s1_idx) == EMIT_COUNT - 1);
      if (live_cur && !expire) begin
        result.flag        <= 1'b1;
        result.pixel_x     <= new_x[POS_W-1 -: PIX_W];
        result.pixel_y     <= new_y[POS_W-1 -: PIX_W];
        result.pixel_color <= phase_color;
      end else begin
        result.flag        <= 1'b0;
        result.pixel_x     <= '0;
        result.pixel_y     <= '0;
        result.pixel_color <= '0;
      end
    end
  end

endmodule

[rtl/particle_pool_age_move_color.sv]
// Particle pool: spawns, ages, moves and colors a fixed set of particle slots.
// Command channel: a request in req is taken on a clock edge with start high
// and busy low. Spawn places the particle in the lowest free slot, clear frees
// all slots, frame walks every slot; request type 3 is dropped silently.
// Result channel: each result sits on result for one cycle with valid high;
// the receiver must take it then, there is no backpressure.
// Spawn and clear answer in the cycle after the transfer, and busy
// stays low, so a new command can follow at once.
// Frame: one slot per cycle through the slot memory read port; busy is high
// through the walk state and the drain state, each slot read is registered and
// its pixel is then registered onto result, with last set on the final pixel.
// Configuration: cfg_we writes cfg_data into color register cfg_addr at once;
// write only while the block is idle.
// Reset: all slots free, colors back to their defaults, no result pending.
module particle_pool_age_move_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ppamc_pkg::req_t               req,
  input  logic                          cfg_we,
  input  logic [ppamc_pkg::CFG_W-1:0]   cfg_addr,
  input  logic [ppamc_pkg::COLOR_W-1:0] cfg_data,
  output ppamc_pkg::result_t            result,
  output logic                          valid
);
  import ppamc_pkg::*;

  cmd_t cmd;

  ppamc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .busy     (busy),
    .cmd      (cmd)
  );

  ppamc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .result   (result),
    .valid    (valid)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ppamc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = SLOT_COUNT + 4;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_addr;
  logic [COLOR_W-1:0] cfg_data;
  result_t result;
  logic valid;

  particle_pool_age_move_color u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .result(result),
    .valid(valid)
  );

  logic                    slot_live [SLOT_COUNT];
  logic [AGE_W-1:0]        slot_age  [SLOT_COUNT];
  logic signed [POS_W-1:0] slot_x    [SLOT_COUNT];
  logic signed [POS_W-1:0] slot_y    [SLOT_COUNT];
  logic signed [VEL_W-1:0] slot_dx   [SLOT_COUNT];
  logic signed [VEL_W-1:0] slot_dy   [SLOT_COUNT];
  logic [COLOR_W-1:0]      palette   [4];

  result_t pool_answers[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic signed [POS_W-1:0] clamp_position(input int sum);
    if (sum > (2 ** (POS_W - 1)) - 1) return POS_W'((2 ** (POS_W - 1)) - 1);
    if (sum < -(2 ** (POS_W - 1))) return POS_W'(-(2 ** (POS_W - 1)));
    return sum[POS_W-1:0];
  endfunction

  task automatic apply_request(input req_t r);
    result_t ans;
    int phase;
    bit placed;
    ans = '0;
    ans.last = 1'b1;
    case (r.req_type)
      REQ_SPAWN: begin
        placed = 0;
        ans.result_kind = KIND_SPAWN;
        for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
          if (!slot_live[i]) begin
            slot_live[i] = 1'b1;
            slot_age[i] = '0;
            slot_x[i] = r.spawn_x;
            slot_y[i] = r.spawn_y;
            slot_dx[i] = r.spawn_dx;
            slot_dy[i] = r.spawn_dy;
            ans.slot_index = INDEX_W'(i);
            ans.flag = 1'b1;
            placed = 1;
          end
        end
        pool_answers.push_back(ans);
      end
      REQ_FRAME: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_live[i]) begin
            slot_age[i] = slot_age[i] + 1'b1;
            if (slot_age[i] > LIFETIME) begin
              slot_live[i] = 1'b0;
              slot_age[i] = '0;
            end else begin
              slot_x[i] = clamp_position(int'(slot_x[i]) + int'(slot_dx[i]));
              slot_y[i] = clamp_position(int'(slot_y[i]) + int'(slot_dy[i]));
            end
          end
        end
        for (int i = 0; i < EMIT_COUNT; i++) begin
          ans = '0;
          ans.result_kind = KIND_PIXEL;
          ans.slot_index = INDEX_W'(i);
          ans.last = (i == EMIT_COUNT - 1);
          if (slot_live[i]) begin
            phase = int'(slot_age[i]) / PHASE_DIV;
            if (phase > 3) phase = 3;
            ans.flag = 1'b1;
            ans.pixel_x = slot_x[i][POS_W-1:8];
            ans.pixel_y = slot_y[i][POS_W-1:8];
            ans.pixel_color = palette[phase[1:0]];
          end
          pool_answers.push_back(ans);
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slot_live[i] = 1'b0;
          slot_age[i] = '0;
        end
        ans.result_kind = KIND_CLEAR;
        pool_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && valid) begin
      if (pool_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", result));
      end else begin
        want = pool_answers.pop_front();
        if (result.result_kind !== want.result_kind)
          report_mismatch($sformatf("result_kind %0d, want %0d",
                                    result.result_kind, want.result_kind));
        if (result.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, want %0d",
                                    result.slot_index, want.slot_index));
        if (result.flag !== want.flag)
          report_mismatch($sformatf("slot %0d flag %b, want %b",
                                    want.slot_index, result.flag, want.flag));
        if (result.pixel_x !== want.pixel_x)
          report_mismatch($sformatf("slot %0d pixel_x %0d, want %0d",
                                    want.slot_index, result.pixel_x, want.pixel_x));
        if (result.pixel_y !== want.pixel_y)
          report_mismatch($sformatf("slot %0d pixel_y %0d, want %0d",
                                    want.slot_index, result.pixel_y, want.pixel_y));
        if (result.pixel_color !== want.pixel_color)
          report_mismatch($sformatf("slot %0d pixel_color %h, want %h",
                                    want.slot_index, result.pixel_color,
                                    want.pixel_color));
        if (result.last !== want.last)
          report_mismatch($sformatf("slot %0d last %b, want %b",
                                    want.slot_index, result.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(r);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      case ($urandom_range(3, 0))
        0: gap = 0;
        1, 2: gap = $urandom_range(4, 1);
        default: gap = $urandom_range(45, 5);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic issue(input req_t r);
    send_request(r);
    pace_sender();
  endtask

  function automatic req_t make_request(input logic [1:0] kind, input int x, input int y,
                                        input int dx, input int dy);
    req_t r;
    r.req_type = kind;
    r.spawn_x = x[POS_W-1:0];
    r.spawn_y = y[POS_W-1:0];
    r.spawn_dx = dx[VEL_W-1:0];
    r.spawn_dy = dy[VEL_W-1:0];
    return r;
  endfunction

  function automatic req_t random_request(input logic [1:0] kind);
    if ($urandom_range(1, 0))
      return make_request(kind, $urandom, $urandom, $urandom, $urandom);
    return make_request(kind, $urandom_range(80000, 0) - 40000,
                        $urandom_range(80000, 0) - 40000,
                        $urandom_range(1200, 0) - 600, $urandom_range(1200, 0) - 600);
  endfunction

  task automatic drain_pool_answers();
    @(negedge clk);
    start <= 1'b0;
    while (pool_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [CFG_W-1:0] addr, input logic [COLOR_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    palette[addr] = data;
  endtask

  task automatic write_color_set(input logic [COLOR_W-1:0] young, input logic [COLOR_W-1:0] mid,
                                 input logic [COLOR_W-1:0] old,
                                 input logic [COLOR_W-1:0] dying);
    write_color(CFG_COLOR_YOUNG, young);
    write_color(CFG_COLOR_MID, mid);
    write_color(CFG_COLOR_OLD, old);
    write_color(CFG_COLOR_DYING, dying);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    issue(make_request(REQ_FRAME, 0, 0, 0, 0));
    issue(make_request(REQ_UNUSED, 0, 0, 0, 0));
    issue(make_request(REQ_SPAWN, 524287, -524288, 32767, -32768));
    issue(make_request(REQ_SPAWN, -524288, 524287, -32768, 32767));
    issue(make_request(REQ_SPAWN, 0, 0, 0, 0));
    issue(make_request(REQ_SPAWN, -1, -1, -1, -1));
    issue(make_request(REQ_SPAWN, 255, -257, 1, -256));
    issue(make_request(REQ_FRAME, 0, 0, 0, 0));
    issue(make_request(REQ_FRAME, 0, 0, 0, 0));
    issue(make_request(REQ_CLEAR, -1, -1, -1, -1));
    issue(make_request(REQ_FRAME, 0, 0, 0, 0));
    issue(make_request(REQ_SPAWN, 'h55555, 'hAAAAA, 'hAAAA, 'h5555));
    issue(make_request(REQ_UNUSED, -1, -1, -1, -1));
    issue(make_request(REQ_SPAWN, 'hAAAAA, 'h55555, 'h5555, 'hAAAA));
    issue(make_request(REQ_FRAME, -1, -1, -1, -1));
    issue(make_request(REQ_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic test_pool_full();
    for (int i = 0; i < SLOT_COUNT + 2; i++) issue(random_request(REQ_SPAWN));
    issue(make_request(REQ_FRAME, 0, 0, 0, 0));
    issue(random_request(REQ_SPAWN));
    issue(make_request(REQ_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic test_lifetime();
    for (int i = 0; i < 6; i++) issue(random_request(REQ_SPAWN));
    for (int f = 0; f < LIFETIME + 3; f++) begin
      issue(random_request(REQ_FRAME));
      if ($urandom_range(3, 0) == 0) issue(random_request(REQ_SPAWN));
    end
    issue(random_request(REQ_SPAWN));
  endtask

  task automatic test_random_mix(input int count);
    int pick;
    int sent;
    sent = 0;
    while (sent < count) begin
      if (sent == count / 2) drain_pool_answers();
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        issue(random_request(REQ_SPAWN));
        sent++;
      end else if (pick < 90) begin
        issue(random_request(REQ_FRAME));
        sent++;
      end else if (pick < 94) begin
        issue(random_request(REQ_CLEAR));
        sent++;
      end else begin
        issue(random_request(REQ_UNUSED));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i] = '0;
      slot_x[i] = '0;
      slot_y[i] = '0;
      slot_dx[i] = '0;
      slot_dy[i] = '0;
    end
    palette[0] = COLOR_YOUNG_RST;
    palette[1] = COLOR_MID_RST;
    palette[2] = COLOR_OLD_RST;
    palette[3] = COLOR_DYING_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    drain_pool_answers();
    write_color_set('0, '0, '0, '0);
    test_pool_full();
    drain_pool_answers();
    write_color_set($urandom, $urandom, $urandom, $urandom);
    test_lifetime();
    drain_pool_answers();
    write_color_set('1, '1, '1, '1);
    test_random_mix(10);
    drain_pool_answers();
    write_color_set($urandom, $urandom, $urandom, $urandom);
    test_random_mix(6);
    drain_pool_answers();

    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ppamc_pkg.sv
rtl/ppamc_ctrl.sv
rtl/ppamc_datapath.sv
rtl/particle_pool_age_move_color.sv
tb/sv/testbench.sv
